FILE: sv/nttv_pkg.sv
package nttv_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic CFG_MAX_BYTES = 1'b0;
    localparam logic CFG_MAX_DEPTH = 1'b1;

    localparam logic [7:0] TAG_NULL    = 8'h00;
    localparam logic [7:0] TAG_BOOL    = 8'h01;
    localparam logic [7:0] TAG_INT     = 8'h02;
    localparam logic [7:0] TAG_BYTES   = 8'h03;
    localparam logic [7:0] TAG_TEXT    = 8'h04;
    localparam logic [7:0] TAG_TUPLE   = 8'h05;

    // bytes in a length field, and the index of its last byte
    localparam int unsigned LEN_BYTES = 8;
    localparam logic [3:0]  LEN_LAST  = 4'd7;

    localparam logic [31:0] MAX_BYTES_RST = 32'd16777216;
    localparam logic [6:0]  MAX_DEPTH_RST = 7'd64;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_TAG       = 4'd1,
        PH_SIGN      = 4'd2,
        PH_BOOL      = 4'd3,
        PH_LEN_INT   = 4'd4,
        PH_LEN_PAY   = 4'd5,
        PH_LEN_COUNT = 4'd6,
        PH_LEN_ITEM  = 4'd7,
        PH_SKIP      = 4'd8,
        PH_DONE      = 4'd9,
        PH_ERROR     = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN    = 2'd0,
        ST_POP_RD = 2'd1,
        ST_POP_EV = 2'd2
    } t_state;

    typedef enum logic [3:0] {
        STAT_OK        = 4'd0,
        STAT_BUNDLE    = 4'd1,
        STAT_DEPTH     = 4'd2,
        STAT_NO_TAG    = 4'd3,
        STAT_BOOL_SIZE = 4'd4,
        STAT_INT_SIGN  = 4'd5,
        STAT_TRUNC     = 4'd6,
        STAT_INT_WIDTH = 4'd7,
        STAT_PAY_SIZE  = 4'd8,
        STAT_COUNT     = 4'd9,
        STAT_ITEM_SIZE = 4'd10,
        STAT_BAD_TAG   = 4'd11,
        STAT_TRAILING  = 4'd12
    } t_status;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_stack_cmd;

endpackage

FILE: sv/nttv_stack.sv
// Level stack: one write port, one read port, registered read data.
module nttv_stack #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  nttv_pkg::t_stack_cmd                   i_cmd,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> ({1'b0, i_wr_addr} < (AW + 1)'(DEPTH)))
        else $error("stack write out of range");
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> ({1'b0, i_rd_addr} < (AW + 1)'(DEPTH)))
        else $error("stack read out of range");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr_en && i_cmd.rd_en))
        else $error("stack read and write in one cycle");
endmodule

FILE: sv/nested_tlv_stream_validator.sv
// Nested TLV bundle shape checker.
// Input channel (i_valid/o_ready) carries requests: command 0 starts a bundle
// of i_bundle_length bytes, command 1 delivers the next byte. A start always
// aborts the bundle in progress. Output channel (o_valid/i_ready) carries at
// most one result per request: the first error with its offset, or status ok
// with the bundle length once the last byte closes the root value.
// Config port: i_cfg_we writes register i_cfg_idx (0 max bundle bytes,
// 1 max nesting depth); write only while idle.
// Timing: a request is taken when o_ready is high, and a result that it raises
// shows the next cycle. A byte that closes a nested value then reads back each
// enclosing level from the level stack memory (read, then evaluate; evaluation
// waits for a free output register). So throughput is one byte per cycle while o_ready is high.
// Reset (synchronous, active low) returns to idle with the limits at their
// defaults; stack contents are not cleared, a slot is written before read.
// A result waits in the output register; while it waits and i_ready is low,
// o_ready drops and no new request is taken.
module nested_tlv_stream_validator #(
    parameter int MAX_LEVELS  = 64,
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_bundle_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_status,
    output logic [31:0] o_error_offset,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CW = $clog2(MAX_LEVELS + 1);
    localparam int OB = OFFSET_BITS;
    localparam int SW = OB + 32;

    // configuration
    logic [31:0] r_max_bytes;
    logic [6:0]  r_max_depth;

    // control
    nttv_pkg::t_state r_state, n_state;
    nttv_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]    r_count, n_count;
    logic [3:0]       r_seen,  n_seen;
    logic             r_ov,    n_ov;

    // datapath
    logic [63:0]      r_acc,        n_acc;
    logic [OB-1:0]    r_pos,        n_pos;
    logic [31:0]      r_bundle_end, n_bundle_end;
    logic [OB-1:0]    r_top_end,    n_top_end;
    logic [31:0]      r_top_items,  n_top_items;
    nttv_pkg::t_status r_stat,      n_stat;
    logic [31:0]      r_off,        n_off;

    // stack
    nttv_pkg::t_stack_cmd stk_cmd;
    logic [AW-1:0]    stk_wr_addr, stk_rd_addr;
    logic [SW-1:0]    stk_wr_data, stk_rd_data;

    logic             out_free, in_acc;
    logic [7:0]       limit;
    logic [OB-1:0]    cursor, rem, ev_end, ev_rem;
    logic [31:0]      ev_items;
    logic [63:0]      acc_new;
    logic [67:0]      nine_len;

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == nttv_pkg::ST_RUN) && out_free;
    assign in_acc   = i_valid && o_ready;
    assign limit    = (8'(r_max_depth) > 8'(MAX_LEVELS)) ? 8'(MAX_LEVELS) : 8'(r_max_depth);
    assign cursor   = r_pos + OB'(1);
    assign rem      = (r_top_end > cursor) ? (r_top_end - cursor) : '0;
    assign ev_end   = stk_rd_data[SW-1:32];
    assign ev_items = stk_rd_data[31:0];
    assign ev_rem   = (ev_end > r_pos) ? (ev_end - r_pos) : '0;
    assign acc_new  = {r_acc[55:0], i_data_byte};
    // 9*len compared with rem stands for len > floor(rem/9)
    assign nine_len = {1'b0, acc_new, 3'b000} + {4'b0000, acc_new};

    nttv_stack #(.DEPTH(MAX_LEVELS), .WIDTH(SW)) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (stk_cmd),
        .i_wr_addr (stk_wr_addr),
        .i_wr_data (stk_wr_data),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data)
    );

    always_comb begin
        logic              do_rep;
        nttv_pkg::t_status rep_stat;
        logic [31:0]       rep_off;
        logic              do_close;
        logic              do_beg;
        nttv_pkg::t_phase  beg_phase;

        n_state      = r_state;
        n_phase      = r_phase;
        n_count      = r_count;
        n_seen       = r_seen;
        n_ov         = r_ov && !i_ready;
        n_acc        = r_acc;
        n_pos        = r_pos;
        n_bundle_end = r_bundle_end;
        n_top_end    = r_top_end;
        n_top_items  = r_top_items;
        n_stat       = r_stat;
        n_off        = r_off;
        stk_cmd      = '0;
        stk_wr_addr  = AW'(r_count - CW'(1));
        stk_rd_addr  = AW'(r_count - CW'(1));
        stk_wr_data  = {r_top_end, r_top_items - 32'd1};
        do_rep       = 1'b0;
        rep_stat     = nttv_pkg::STAT_OK;
        rep_off      = '0;
        do_close     = 1'b0;
        do_beg       = 1'b0;
        beg_phase    = nttv_pkg::PH_LEN_ITEM;

        case (r_state)
            nttv_pkg::ST_RUN: begin
                if (in_acc && i_command == nttv_pkg::CMD_START) begin
                    n_count      = '0;
                    n_pos        = '0;
                    n_acc        = '0;
                    n_seen       = '0;
                    n_bundle_end = i_bundle_length;
                    if (i_bundle_length == 32'd0 || i_bundle_length > r_max_bytes
                            || (64'(i_bundle_length) >> OB) != 64'd0) begin
                        do_rep   = 1'b1;
                        rep_stat = nttv_pkg::STAT_BUNDLE;
                    end else if (limit == 8'd0) begin
                        do_rep   = 1'b1;
                        rep_stat = nttv_pkg::STAT_DEPTH;
                    end else begin
                        n_top_end   = OB'(i_bundle_length);
                        n_top_items = '0;
                        n_count     = CW'(1);
                        n_phase     = nttv_pkg::PH_TAG;
                    end
                end else if (in_acc && r_phase != nttv_pkg::PH_IDLE
                        && r_phase != nttv_pkg::PH_DONE && r_phase != nttv_pkg::PH_ERROR) begin
                    n_pos   = cursor;
                    rep_off = 32'(cursor);
                    case (r_phase)
                        nttv_pkg::PH_TAG: begin
                            case (i_data_byte)
                                nttv_pkg::TAG_NULL: begin
                                    if (rem != '0) begin
                                        do_rep   = 1'b1;
                                        rep_stat = nttv_pkg::STAT_TRAILING;
                                    end else begin
                                        do_close = 1'b1;
                                    end
                                end
                                nttv_pkg::TAG_BOOL: begin
                                    if (rem != OB'(1)) begin
                                        do_rep   = 1'b1;
                                        rep_stat = nttv_pkg::STAT_BOOL_SIZE;
                                    end else begin
                                        n_phase = nttv_pkg::PH_BOOL;
                                    end
                                end
                                nttv_pkg::TAG_INT: begin
                                    if (rem == '0) begin
                                        do_rep   = 1'b1;
                                        rep_stat = nttv_pkg::STAT_INT_SIGN;
                                    end else begin
                                        n_phase = nttv_pkg::PH_SIGN;
                                    end
                                end
                                nttv_pkg::TAG_BYTES, nttv_pkg::TAG_TEXT: begin
                                    do_beg    = 1'b1;
                                    beg_phase = nttv_pkg::PH_LEN_PAY;
                                end
                                nttv_pkg::TAG_TUPLE: begin
                                    do_beg    = 1'b1;
                                    beg_phase = nttv_pkg::PH_LEN_COUNT;
                                end
                                default: begin
                                    do_rep   = 1'b1;
                                    rep_stat = nttv_pkg::STAT_BAD_TAG;
                                end
                            endcase
                        end
                        nttv_pkg::PH_SIGN: begin
                            do_beg    = 1'b1;
                            beg_phase = nttv_pkg::PH_LEN_INT;
                        end
                        nttv_pkg::PH_BOOL: do_close = 1'b1;
                        nttv_pkg::PH_SKIP: do_close = (cursor >= r_top_end);
                        default: begin
                            n_acc  = acc_new;
                            n_seen = r_seen + 4'd1;
                            if (r_seen == nttv_pkg::LEN_LAST) begin
                                if (r_phase == nttv_pkg::PH_LEN_COUNT) begin
                                    if (nine_len > 68'(rem)) begin
                                        do_rep   = 1'b1;
                                        rep_stat = nttv_pkg::STAT_COUNT;
                                    end else begin
                                        n_top_items = acc_new[31:0];
                                        if (acc_new != 64'd0) begin
                                            do_beg = 1'b1;
                                        end else if (rem != '0) begin
                                            do_rep   = 1'b1;
                                            rep_stat = nttv_pkg::STAT_TRAILING;
                                        end else begin
                                            do_close = 1'b1;
                                        end
                                    end
                                end else if (r_phase == nttv_pkg::PH_LEN_ITEM) begin
                                    if (acc_new == 64'd0 || acc_new > 64'(rem)) begin
                                        do_rep   = 1'b1;
                                        rep_stat = nttv_pkg::STAT_ITEM_SIZE;
                                    end else if (8'(r_count) >= limit
                                            || 8'(r_count) >= 8'(MAX_LEVELS)) begin
                                        do_rep   = 1'b1;
                                        rep_stat = nttv_pkg::STAT_DEPTH;
                                    end else begin
                                        // push the enclosing tuple, open the item
                                        stk_cmd.wr_en = 1'b1;
                                        n_top_end     = cursor + OB'(acc_new);
                                        n_top_items   = '0;
                                        n_count       = r_count + CW'(1);
                                        n_phase       = nttv_pkg::PH_TAG;
                                    end
                                end else begin
                                    if (acc_new > 64'(rem)) begin
                                        do_rep   = 1'b1;
                                        rep_stat = (r_phase == nttv_pkg::PH_LEN_INT)
                                            ? nttv_pkg::STAT_INT_WIDTH : nttv_pkg::STAT_PAY_SIZE;
                                    end else if (acc_new < 64'(rem)) begin
                                        do_rep   = 1'b1;
                                        rep_stat = nttv_pkg::STAT_TRAILING;
                                        rep_off  = 32'(64'(cursor) + acc_new);
                                    end else if (rem == '0) begin
                                        do_close = 1'b1;
                                    end else begin
                                        n_phase = nttv_pkg::PH_SKIP;
                                    end
                                end
                            end
                        end
                    endcase
                end

                if (do_beg) begin
                    if (rem < OB'(nttv_pkg::LEN_BYTES)) begin
                        do_rep   = 1'b1;
                        rep_stat = nttv_pkg::STAT_TRUNC;
                    end else begin
                        n_phase = beg_phase;
                        n_acc   = '0;
                        n_seen  = '0;
                    end
                end

                if (do_close) begin
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        do_rep   = 1'b1;
                        rep_stat = nttv_pkg::STAT_OK;
                        rep_off  = r_bundle_end;
                    end else begin
                        n_state = nttv_pkg::ST_POP_RD;
                    end
                end
            end

            nttv_pkg::ST_POP_RD: begin
                stk_cmd.rd_en = 1'b1;
                n_state       = nttv_pkg::ST_POP_EV;
            end

            nttv_pkg::ST_POP_EV: begin
                if (out_free) begin
                    n_top_end   = ev_end;
                    n_top_items = ev_items;
                    n_state     = nttv_pkg::ST_RUN;
                    rep_off     = 32'(r_pos);
                    if (ev_items != 32'd0) begin
                        if (ev_rem < OB'(nttv_pkg::LEN_BYTES)) begin
                            do_rep   = 1'b1;
                            rep_stat = nttv_pkg::STAT_TRUNC;
                        end else begin
                            n_phase = nttv_pkg::PH_LEN_ITEM;
                            n_acc   = '0;
                            n_seen  = '0;
                        end
                    end else if (r_pos != ev_end) begin
                        do_rep   = 1'b1;
                        rep_stat = nttv_pkg::STAT_TRAILING;
                    end else begin
                        n_count = r_count - CW'(1);
                        if (r_count == CW'(1)) begin
                            do_rep   = 1'b1;
                            rep_stat = nttv_pkg::STAT_OK;
                            rep_off  = r_bundle_end;
                        end else begin
                            n_state = nttv_pkg::ST_POP_RD;
                        end
                    end
                end
            end

            default: n_state = nttv_pkg::ST_RUN;
        endcase

        if (do_rep) begin
            n_ov    = 1'b1;
            n_stat  = rep_stat;
            n_off   = rep_off;
            n_phase = (rep_stat == nttv_pkg::STAT_OK) ? nttv_pkg::PH_DONE : nttv_pkg::PH_ERROR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nttv_pkg::ST_RUN;
            r_phase     <= nttv_pkg::PH_IDLE;
            r_count     <= '0;
            r_seen      <= '0;
            r_ov        <= 1'b0;
            r_max_bytes <= nttv_pkg::MAX_BYTES_RST;
            r_max_depth <= nttv_pkg::MAX_DEPTH_RST;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_seen  <= n_seen;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nttv_pkg::CFG_MAX_BYTES: r_max_bytes <= i_cfg_data;
                    nttv_pkg::CFG_MAX_DEPTH: r_max_depth <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_pos        <= n_pos;
        r_bundle_end <= n_bundle_end;
        r_top_end    <= n_top_end;
        r_top_items  <= n_top_items;
        r_stat       <= n_stat;
        r_off        <= n_off;
    end

    assign o_valid        = r_ov;
    assign o_status       = r_stat;
    assign o_error_offset = r_off;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        8'(r_count) <= 8'(MAX_LEVELS))
        else $error("level count above stack depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != nttv_pkg::ST_RUN) |-> (r_count != '0))
        else $error("pop with empty stack");
    a_pop_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nttv_pkg::ST_POP_RD) |=> (r_state == nttv_pkg::ST_POP_EV))
        else $error("stack read not followed by evaluation");
    a_skip_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nttv_pkg::ST_RUN && r_phase == nttv_pkg::PH_SKIP) |-> (r_pos < r_top_end))
        else $error("skip cursor past value end");
endmodule

FILE: tb/tb_top.sv
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [31:0] bundle_len;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  status;
    logic [31:0] err_offset;
    logic        cfg_we;
    logic        cfg_idx;
    logic [31:0] cfg_data;

    nested_tlv_stream_validator u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_command       (cmd),
        .i_bundle_length (bundle_len),
        .i_data_byte     (data_byte),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_status        (status),
        .o_error_offset  (err_offset),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one request on the input channel
    typedef struct {
        logic        cmd;
        logic [31:0] len;
        logic [7:0]  data;
    } t_req;

    // one verdict on the output channel
    typedef struct {
        nttv_pkg::t_status st;
        logic [31:0]       off;
    } t_verdict;

    // ------------------------------------------------------------------
    // Shape checker mirror: state and limits
    // ------------------------------------------------------------------
    logic [31:0]      lim_bytes;
    logic [6:0]       lim_depth;
    logic [63:0]      span_end   [64];
    logic [31:0]      items_left [64];
    int unsigned      depth;
    nttv_pkg::t_phase phase;
    logic [63:0]      len_acc;
    int unsigned      len_seen;
    logic [63:0]      pos;
    logic [63:0]      total_len;

    t_verdict verdicts_due[$];
    int       fails;
    bit       quiet;     // last part of run: no idling
    bit       feeding;   // sender still has requests to give

    function automatic int unsigned top_idx();
        return (depth >= 1 && depth <= 64) ? depth - 1 : 0;
    endfunction

    function automatic logic [63:0] room(logic [63:0] e, logic [63:0] c);
        return e > c ? e - c : 64'd0;
    endfunction

    function automatic void post(nttv_pkg::t_status s, logic [63:0] off);
        t_verdict v;
        v.st  = s;
        v.off = off[31:0];
        verdicts_due = {verdicts_due, v};
        phase = (s != nttv_pkg::STAT_OK) ? nttv_pkg::PH_ERROR : nttv_pkg::PH_DONE;
    endfunction

    function automatic void open_len(nttv_pkg::t_phase p, logic [63:0] c, logic [63:0] e);
        if (room(e, c) < 64'd8) begin
            post(nttv_pkg::STAT_TRUNC, c);
            return;
        end
        phase    = p;
        len_acc  = 0;
        len_seen = 0;
    endfunction

    // pop finished values; enclosing tuples either expect the next item
    // size or must end exactly at the cursor
    function automatic void pop_values(logic [63:0] c);
        int unsigned t;
        forever begin
            if (depth > 0) depth--;
            if (depth == 0) begin
                post(nttv_pkg::STAT_OK, total_len);
                return;
            end
            t = top_idx();
            if (items_left[t] > 0) begin
                open_len(nttv_pkg::PH_LEN_ITEM, c, span_end[t]);
                return;
            end
            if (c != span_end[t]) begin
                post(nttv_pkg::STAT_TRAILING, c);
                return;
            end
        end
    endfunction

    function automatic void predict_shape(t_req r);
        int unsigned lim;
        int unsigned t;
        logic [63:0] c, e, rem, n;
        lim = (lim_depth > 7'd64) ? 64 : 32'(lim_depth);
        if (r.cmd == nttv_pkg::CMD_START) begin
            depth     = 0;
            pos       = 0;
            len_acc   = 0;
            len_seen  = 0;
            total_len = {32'd0, r.len};
            if (r.len == 32'd0 || r.len > lim_bytes) begin
                post(nttv_pkg::STAT_BUNDLE, 64'd0);
                return;
            end
            if (lim < 1) begin
                post(nttv_pkg::STAT_DEPTH, 64'd0);
                return;
            end
            span_end[0]   = {32'd0, r.len};
            items_left[0] = 0;
            depth         = 1;
            phase         = nttv_pkg::PH_TAG;
            return;
        end
        if (phase == nttv_pkg::PH_IDLE || phase == nttv_pkg::PH_DONE
                || phase == nttv_pkg::PH_ERROR) return;
        c   = pos + 64'd1;
        pos = c;
        t   = top_idx();
        e   = span_end[t];
        rem = room(e, c);
        case (phase)
            nttv_pkg::PH_TAG: begin
                case (r.data)
                    nttv_pkg::TAG_NULL: begin
                        if (rem != 0) post(nttv_pkg::STAT_TRAILING, c);
                        else pop_values(c);
                    end
                    nttv_pkg::TAG_BOOL: begin
                        if (rem != 1) post(nttv_pkg::STAT_BOOL_SIZE, c);
                        else phase = nttv_pkg::PH_BOOL;
                    end
                    nttv_pkg::TAG_INT: begin
                        if (rem == 0) post(nttv_pkg::STAT_INT_SIGN, c);
                        else phase = nttv_pkg::PH_SIGN;
                    end
                    nttv_pkg::TAG_BYTES, nttv_pkg::TAG_TEXT:
                        open_len(nttv_pkg::PH_LEN_PAY, c, e);
                    nttv_pkg::TAG_TUPLE:
                        open_len(nttv_pkg::PH_LEN_COUNT, c, e);
                    default: post(nttv_pkg::STAT_BAD_TAG, c);
                endcase
                return;
            end
            nttv_pkg::PH_SIGN: begin
                open_len(nttv_pkg::PH_LEN_INT, c, e);
                return;
            end
            nttv_pkg::PH_BOOL: begin
                pop_values(c);
                return;
            end
            nttv_pkg::PH_SKIP: begin
                if (c >= e) pop_values(c);
                return;
            end
            default: ;
        endcase
        // length fields, big endian
        len_acc = {len_acc[55:0], r.data};
        len_seen++;
        if (len_seen < nttv_pkg::LEN_BYTES) return;
        n = len_acc;
        if (phase == nttv_pkg::PH_LEN_INT || phase == nttv_pkg::PH_LEN_PAY) begin
            if (n > rem)
                post(phase == nttv_pkg::PH_LEN_INT ? nttv_pkg::STAT_INT_WIDTH
                                                   : nttv_pkg::STAT_PAY_SIZE, c);
            else if (n < rem)
                post(nttv_pkg::STAT_TRAILING, c + n);
            else if (rem == 0)
                pop_values(c);
            else
                phase = nttv_pkg::PH_SKIP;
            return;
        end
        if (phase == nttv_pkg::PH_LEN_COUNT) begin
            if (n > rem / 9) begin
                post(nttv_pkg::STAT_COUNT, c);
                return;
            end
            items_left[t] = n[31:0];
            if (n > 0) open_len(nttv_pkg::PH_LEN_ITEM, c, e);
            else if (rem != 0) post(nttv_pkg::STAT_TRAILING, c);
            else pop_values(c);
            return;
        end
        if (n == 0 || n > rem) begin
            post(nttv_pkg::STAT_ITEM_SIZE, c);
            return;
        end
        items_left[t]--;
        if (depth >= lim || depth >= 64) begin
            post(nttv_pkg::STAT_DEPTH, c);
            return;
        end
        span_end[depth]   = c + n;
        items_left[depth] = 0;
        depth++;
        phase = nttv_pkg::PH_TAG;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------
    int unsigned hold_rx;
    int unsigned idle_cycles;

    always @(posedge clk) begin
        t_verdict v;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected result status=%0d offset=%0d",
                             $time, status, err_offset);
                    fails++;
                end else begin
                    v = verdicts_due.pop_front();
                    if (status !== v.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, v.st, status);
                        fails++;
                    end
                    if (err_offset !== v.off) begin
                        $display("%0t: offset expected %0d actual %0d",
                                 $time, v.off, err_offset);
                        fails++;
                    end
                end
            end
            // stall bursts on the receive side
            if (quiet) begin
                out_ready <= 1'b1;
            end else if (hold_rx > 0) begin
                hold_rx--;
            end else if (out_ready && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                hold_rx   = $urandom_range(1, 16);
            end else begin
                out_ready <= 1'b1;
            end
            // watchdog: cycles with no request or result accepted
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else if (feeding || verdicts_due.size() != 0) idle_cycles++;
            if (idle_cycles > 5000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // present one request and wait for it to be taken; optional gap first
    task automatic send_req(t_req r);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= r.cmd;
        bundle_len <= r.len;
        data_byte  <= r.data;
        predict_shape(r);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        // pops on deep closes can still be running
        repeat (140) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == nttv_pkg::CFG_MAX_BYTES) lim_bytes = val;
        else lim_depth = val[6:0];
        @(posedge clk);
    endtask

    function automatic t_req mk(logic c, logic [31:0] l, logic [7:0] d);
        t_req r;
        r.cmd  = c;
        r.len  = l;
        r.data = d;
        return r;
    endfunction

    // bundle under construction
    logic [7:0] bld[$];

    function automatic void add_byte(logic [7:0] b);
        bld = {bld, b};
    endfunction

    function automatic void put_len(logic [63:0] v);
        for (int i = 7; i >= 0; i--) add_byte(v[i*8 +: 8]);
    endfunction

    // emit one random value of exact size sz; sizes 3 to 8 give a null with trailing bytes
    function automatic void build_value(int unsigned sz, int unsigned lvl);
        int unsigned k, left, part;
        if (sz == 1) begin
            add_byte(nttv_pkg::TAG_NULL);
            return;
        end
        if (sz == 2) begin
            add_byte(nttv_pkg::TAG_BOOL);
            add_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (sz >= 10 && $urandom_range(0, 3) == 0) begin
            add_byte(nttv_pkg::TAG_INT);
            add_byte(8'($urandom_range(0, 255)));
            put_len(64'(sz - 10));
            repeat (sz - 10) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (sz >= 9 && lvl < 6 && $urandom_range(0, 1) == 0) begin
            // tuple: count then items each with 8-byte size
            left = sz - 9;
            k = 0;
            if (left >= 9) k = $urandom_range(0, (left / 9 > 3) ? 3 : left / 9);
            if (k == 0 && left != 0) k = 1;
            if (k == 1 && left < 9) k = 0;
            if (k == 0 && left != 0) begin
                add_byte(nttv_pkg::TAG_BYTES);
                put_len(64'(sz - 9));
                repeat (sz - 9) add_byte(8'($urandom_range(0, 255)));
                return;
            end
            add_byte(nttv_pkg::TAG_TUPLE);
            put_len(64'(k));
            for (int unsigned i = 0; i < k; i++) begin
                part = (i == k - 1) ? left - 8 :
                       $urandom_range(1, left - 8 - 9 * (k - 1 - i));
                put_len(64'(part));
                build_value(part, lvl + 1);
                left -= part + 8;
            end
            return;
        end
        if (sz >= 9) begin
            add_byte($urandom_range(0, 1) ? nttv_pkg::TAG_BYTES : nttv_pkg::TAG_TEXT);
            put_len(64'(sz - 9));
            repeat (sz - 9) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        add_byte(nttv_pkg::TAG_NULL);
        repeat (sz - 1) add_byte(8'h00);   // trailing bytes
    endfunction

    // ------------------------------------------------------------------
    // Directed table: start/data rows; exp_st/off used where obvious
    // ------------------------------------------------------------------
    typedef struct {
        logic              cmd;
        logic [31:0]       len;
        logic [7:0]        data;
        bit                typed;
        nttv_pkg::t_status st;
        logic [31:0]       off;
    } t_row;

    t_row table_rows[$];

    function automatic void row(logic c, logic [31:0] l, logic [7:0] d,
                                bit ty = 0, nttv_pkg::t_status s = nttv_pkg::STAT_OK,
                                logic [31:0] o = 0);
        t_row r;
        r.cmd = c; r.len = l; r.data = d; r.typed = ty; r.st = s; r.off = o;
        table_rows = {table_rows, r};
    endfunction

    initial begin
        int unsigned sent;
        int unsigned sz;
        t_req r;
        t_verdict tv;
        fails       = 0;
        quiet       = 0;
        feeding     = 1;
        hold_rx     = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        cmd         = nttv_pkg::CMD_START;
        bundle_len  = 0;
        data_byte   = 0;
        cfg_we      = 1'b0;
        cfg_idx     = nttv_pkg::CFG_MAX_BYTES;
        cfg_data    = 0;
        lim_bytes   = nttv_pkg::MAX_BYTES_RST;
        lim_depth   = nttv_pkg::MAX_DEPTH_RST;
        depth       = 0;
        phase       = nttv_pkg::PH_IDLE;
        pos         = 0;
        total_len   = 0;
        len_acc     = 0;
        len_seen    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // data while idle is dropped; zero and oversize lengths
        row(nttv_pkg::CMD_DATA,  0, 8'hFF);
        row(nttv_pkg::CMD_START, 0, 0, 1, nttv_pkg::STAT_BUNDLE, 0);
        row(nttv_pkg::CMD_START, 32'hFFFF_FFFF, 0, 1, nttv_pkg::STAT_BUNDLE, 0);
        // single null: ok with bundle length
        row(nttv_pkg::CMD_START, 1, 0);
        row(nttv_pkg::CMD_DATA,  0, nttv_pkg::TAG_NULL, 1, nttv_pkg::STAT_OK, 1);
        // boolean, byte unchecked
        row(nttv_pkg::CMD_START, 2, 0);
        row(nttv_pkg::CMD_DATA,  0, nttv_pkg::TAG_BOOL);
        row(nttv_pkg::CMD_DATA,  0, 8'hFF, 1, nttv_pkg::STAT_OK, 2);
        // boolean with wrong span
        row(nttv_pkg::CMD_START, 3, 0);
        row(nttv_pkg::CMD_DATA,  0, nttv_pkg::TAG_BOOL, 1, nttv_pkg::STAT_BOOL_SIZE, 1);
        // integer with no sign byte
        row(nttv_pkg::CMD_START, 1, 0);
        row(nttv_pkg::CMD_DATA,  0, nttv_pkg::TAG_INT, 1, nttv_pkg::STAT_INT_SIGN, 1);
        // truncated length field
        row(nttv_pkg::CMD_START, 4, 0);
        row(nttv_pkg::CMD_DATA,  0, nttv_pkg::TAG_TUPLE, 1, nttv_pkg::STAT_TRUNC, 1);
        // unknown tag, null with trailing bytes
        row(nttv_pkg::CMD_START, 5, 0);
        row(nttv_pkg::CMD_DATA,  0, 8'hFF, 1, nttv_pkg::STAT_BAD_TAG, 1);
        row(nttv_pkg::CMD_START, 5, 0);
        row(nttv_pkg::CMD_DATA,  0, nttv_pkg::TAG_NULL, 1, nttv_pkg::STAT_TRAILING, 1);
        // payload size too big
        row(nttv_pkg::CMD_START, 9, 0);
        row(nttv_pkg::CMD_DATA,  0, nttv_pkg::TAG_TEXT);
        for (int i = 0; i < 7; i++) row(nttv_pkg::CMD_DATA, 0, 8'h00);
        row(nttv_pkg::CMD_DATA,  0, 8'h01, 1, nttv_pkg::STAT_PAY_SIZE, 9);

        foreach (table_rows[i]) begin
            r = mk(table_rows[i].cmd, table_rows[i].len, table_rows[i].data);
            send_req(r);
            if (table_rows[i].typed) begin
                tv = verdicts_due[verdicts_due.size() - 1];
                if (tv.st != table_rows[i].st || tv.off != table_rows[i].off) begin
                    $display("%0t: table row %0d expected %0d/%0d predicted %0d/%0d",
                             $time, i, table_rows[i].st, table_rows[i].off,
                             tv.st, tv.off);
                    fails++;
                end
            end
        end
        drain();

        // random part across limit settings, extremes included
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(nttv_pkg::CFG_MAX_DEPTH, 32'd0);
                    write_reg(nttv_pkg::CFG_MAX_BYTES, 32'hFFFF_FFFF);
                end
                1: begin
                    write_reg(nttv_pkg::CFG_MAX_DEPTH, 32'd1);
                    write_reg(nttv_pkg::CFG_MAX_BYTES, 32'd1);
                end
                2: begin
                    write_reg(nttv_pkg::CFG_MAX_DEPTH, 32'd2);
                    write_reg(nttv_pkg::CFG_MAX_BYTES, 32'd60);
                end
                3: write_reg(nttv_pkg::CFG_MAX_DEPTH, 32'h7F);
                4: begin
                    write_reg(nttv_pkg::CFG_MAX_DEPTH, 32'd3);
                    write_reg(nttv_pkg::CFG_MAX_BYTES, 32'd200);
                end
                default: begin
                    write_reg(nttv_pkg::CFG_MAX_DEPTH, 32'd64);
                    write_reg(nttv_pkg::CFG_MAX_BYTES, 32'hFFFF_FFFF);
                    quiet = 1;
                end
            endcase
            while (sent < (ph + 1) * 110) begin
                bld = {};
                sz = $urandom_range(1, 70);
                build_value(sz, 1);
                // occasional corruption
                if ($urandom_range(0, 4) == 0)
                    bld[$urandom_range(0, bld.size() - 1)] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 9) == 0) sz = $urandom_range(0, 80);
                if ($urandom_range(0, 29) == 0) sz = $urandom();
                send_req(mk(nttv_pkg::CMD_START, sz, 8'($urandom_range(0, 255))));
                sent++;
                // sometimes cut short, with a fresh start aborting it
                foreach (bld[i]) begin
                    if ($urandom_range(0, 150) == 0) break;
                    send_req(mk(nttv_pkg::CMD_DATA, $urandom(), bld[i]));
                    sent++;
                end
                if ($urandom_range(0, 5) == 0) begin
                    send_req(mk(nttv_pkg::CMD_DATA, $urandom(), 8'($urandom_range(0, 255))));
                    sent++;
                end
            end
            drain();
        end
        feeding = 0;

        if (fails == 0 && verdicts_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: nested_tlv_stream_validator.f
sv/nttv_pkg.sv
sv/nttv_stack.sv
sv/nested_tlv_stream_validator.sv
tb/tb_top.sv
